// ----- hw/rtl/lcdwcs_pkg.sv -----
`default_nettype none

package lcdwcs_pkg;

    // Panel command opcodes.
    localparam logic [7:0] CMD_CASET  = 8'h2A;
    localparam logic [7:0] CMD_PASET  = 8'h2B;
    localparam logic [7:0] CMD_RAMWR  = 8'h2C;
    localparam logic [7:0] CMD_RAMWRC = 8'h3C;

    // Marker for a stored edge that holds nothing yet.
    localparam logic [11:0] EDGE_NONE = 12'hFFF;

    // Depth of the window queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One drawing rectangle.
    typedef struct packed {
        logic [9:0]  left_col;
        logic [9:0]  top_row;
        logic [10:0] win_width;
        logic [10:0] win_height;
    } rect_req_t;

    // One byte for the panel.
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       is_data;
        logic       last_of_run;
    } spi_byte_t;

    // A classified rectangle: edges plus which parts of the run to send.
    typedef struct packed {
        logic [9:0]  left;
        logic [11:0] right;
        logic [9:0]  top;
        logic [11:0] bottom;
        logic        col_send;
        logic        col_hi;
        logic        page_send;
        logic        page_hi;
        logic        tall;
    } win_cmd_t;

    // Steps of the byte sequencer.
    typedef enum logic [3:0] {
        ST_START,
        ST_CASET,
        ST_XS_HI,
        ST_XS_LO,
        ST_XE_HI,
        ST_XE_LO,
        ST_PASET,
        ST_YS_HI,
        ST_YS_LO,
        ST_YE_HI,
        ST_YE_LO,
        ST_RAMWR,
        ST_RAMWRC
    } seq_step_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcd_window_command_sequencer_core.sv -----
`default_nettype none

// LCD address-window command sequencer. Each accepted rectangle (left, top,
// width, height) becomes a run of 1 to 12 panel bytes: an optional column
// window (0x2A with start and end edges, end edge only when it moved), an
// optional page window (0x2B, same rule), then 0x2C and, for windows taller
// than one row, 0x3C; the last byte of each run carries last_of_run. The
// front stage classifies a rectangle against the stored windows in the cycle
// it is accepted and can take a new one every cycle while the four-entry
// window queue has room. The back stage emits one byte per cycle while the
// receiver is ready, through a registered output, so a rectangle takes one
// output slot per byte (1 to 12); the byte-wide output port sets the sustained
// rate. When the back stage is idle, the first byte of a run passes through the
// window queue and then the output register before it is presented.
module lcd_window_command_sequencer_core #(
    parameter int PANEL_WIDTH = 320
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lcdwcs_pkg::rect_req_t s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lcdwcs_pkg::spi_byte_t      m_data
);
    import lcdwcs_pkg::*;

    localparam logic [11:0] LAST_COL = 12'(PANEL_WIDTH - 1);

    win_cmd_t front_cmd;
    win_cmd_t head_cmd;
    logic     q_full;
    logic     head_valid;
    logic     pop;
    logic     req_fire;

    // Requests are taken whenever the window queue has space.
    assign s_ready  = !q_full;
    assign req_fire = s_valid && s_ready;

    lcdwcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .last_col (LAST_COL),
        .req_fire (req_fire),
        .req      (s_data),
        .cmd      (front_cmd)
    );

    lcdwcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (req_fire),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lcdwcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lcdwcs_front.sv -----
`default_nettype none

module lcdwcs_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [11:0]         last_col,
    input  wire logic                req_fire,
    input  wire lcdwcs_pkg::rect_req_t req,
    output lcdwcs_pkg::win_cmd_t     cmd
);
    import lcdwcs_pkg::*;

    logic [11:0] prev_left_reg,   prev_left_next;
    logic [11:0] prev_right_reg,  prev_right_next;
    logic [11:0] prev_top_reg,    prev_top_next;
    logic [11:0] prev_bottom_reg, prev_bottom_next;

    logic [10:0] width_eff;
    logic [10:0] height_eff;
    logic        height_one;
    logic [11:0] right_raw;
    logic [11:0] right;
    logic [11:0] bottom;
    logic        col_change;
    logic        page_change;

    // Zero sizes count as one pixel.
    always_comb begin
        width_eff  = (req.win_width == 11'd0) ? 11'd1 : req.win_width;
        height_eff = (req.win_height == 11'd0) ? 11'd1 : req.win_height;
        height_one = (height_eff == 11'd1);
    end

    // Edge arithmetic; a single-row window reaches to the stored right edge
    // when that lies further right, otherwise to the last panel column.
    always_comb begin
        right_raw = {2'b00, req.left_col} + {1'b0, width_eff} - 12'd1;
        bottom    = {2'b00, req.top_row} + {1'b0, height_eff} - 12'd1;
        if (height_one) begin
            if ((prev_right_reg != EDGE_NONE) && (prev_right_reg > right_raw)) begin
                right = prev_right_reg;
            end else begin
                right = last_col;
            end
        end else begin
            right = right_raw;
        end
    end

    // Compare with the stored windows and build the command descriptor.
    always_comb begin
        col_change    = ({2'b00, req.left_col} != prev_left_reg) || (right != prev_right_reg);
        page_change   = ({2'b00, req.top_row} != prev_top_reg) || (bottom != prev_bottom_reg);
        cmd.left      = req.left_col;
        cmd.right     = right;
        cmd.top       = req.top_row;
        cmd.bottom    = bottom;
        cmd.col_send  = col_change;
        cmd.col_hi    = (right != prev_right_reg);
        cmd.page_send = page_change;
        cmd.page_hi   = (bottom != prev_bottom_reg);
        cmd.tall      = !height_one;
    end

    // The stored windows follow every accepted rectangle that changes them.
    always_comb begin
        prev_left_next   = prev_left_reg;
        prev_right_next  = prev_right_reg;
        prev_top_next    = prev_top_reg;
        prev_bottom_next = prev_bottom_reg;
        if (req_fire && col_change) begin
            prev_left_next  = {2'b00, req.left_col};
            prev_right_next = right;
        end
        if (req_fire && page_change) begin
            prev_top_next    = {2'b00, req.top_row};
            prev_bottom_next = bottom;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_left_reg   <= EDGE_NONE;
            prev_right_reg  <= EDGE_NONE;
            prev_top_reg    <= EDGE_NONE;
            prev_bottom_reg <= EDGE_NONE;
        end else begin
            prev_left_reg   <= prev_left_next;
            prev_right_reg  <= prev_right_next;
            prev_top_reg    <= prev_top_next;
            prev_bottom_reg <= prev_bottom_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdwcs_queue.sv -----
`default_nettype none

module lcdwcs_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire lcdwcs_pkg::win_cmd_t push_cmd,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output lcdwcs_pkg::win_cmd_t      head_cmd
);
    import lcdwcs_pkg::*;

    win_cmd_t entry_reg [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg,  count_next;

    always_comb begin
        full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
        head_valid = (count_reg != '0);
        head_cmd   = entry_reg[rd_ptr_reg];
    end

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("window queue written while full");
    a_ptrs_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("window queue pointers disagree with fill count");
    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("window queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lcdwcs_back.sv -----
`default_nettype none

module lcdwcs_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 head_valid,
    input  wire lcdwcs_pkg::win_cmd_t head_cmd,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lcdwcs_pkg::spi_byte_t     m_data
);
    import lcdwcs_pkg::*;

    seq_step_t step_reg, step_next;
    seq_step_t cur_step;
    seq_step_t page_step;

    spi_byte_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    logic      fire;
    logic      is_last;

    // A new byte is produced when a descriptor waits and the output slot frees.
    always_comb begin
        fire = head_valid && (!out_valid_reg || m_ready);
    end

    // The step to issue now; a fresh descriptor starts at its first part.
    always_comb begin
        page_step = head_cmd.page_send ? ST_PASET : ST_RAMWR;
        if (step_reg == ST_START) begin
            cur_step = head_cmd.col_send ? ST_CASET : page_step;
        end else begin
            cur_step = step_reg;
        end
    end

    // Next-step logic.
    always_comb begin
        step_next = step_reg;
        if (fire) begin
            case (cur_step)
                ST_CASET:  step_next = ST_XS_HI;
                ST_XS_HI:  step_next = ST_XS_LO;
                ST_XS_LO:  step_next = head_cmd.col_hi ? ST_XE_HI : page_step;
                ST_XE_HI:  step_next = ST_XE_LO;
                ST_XE_LO:  step_next = page_step;
                ST_PASET:  step_next = ST_YS_HI;
                ST_YS_HI:  step_next = ST_YS_LO;
                ST_YS_LO:  step_next = head_cmd.page_hi ? ST_YE_HI : ST_RAMWR;
                ST_YE_HI:  step_next = ST_YE_LO;
                ST_YE_LO:  step_next = ST_RAMWR;
                ST_RAMWR:  step_next = head_cmd.tall ? ST_RAMWRC : ST_START;
                ST_RAMWRC: step_next = ST_START;
                default:   step_next = ST_START;
            endcase
        end
    end

    // Byte, marker and end-of-run flag for the current step.
    always_comb begin
        out_next.spi_byte = CMD_RAMWR;
        out_next.is_data  = 1'b0;
        is_last           = 1'b0;
        case (cur_step)
            ST_CASET: begin
                out_next.spi_byte = CMD_CASET;
            end
            ST_XS_HI: begin
                out_next.spi_byte = {6'b0, head_cmd.left[9:8]};
                out_next.is_data  = 1'b1;
            end
            ST_XS_LO: begin
                out_next.spi_byte = head_cmd.left[7:0];
                out_next.is_data  = 1'b1;
            end
            ST_XE_HI: begin
                out_next.spi_byte = {4'b0, head_cmd.right[11:8]};
                out_next.is_data  = 1'b1;
            end
            ST_XE_LO: begin
                out_next.spi_byte = head_cmd.right[7:0];
                out_next.is_data  = 1'b1;
            end
            ST_PASET: begin
                out_next.spi_byte = CMD_PASET;
            end
            ST_YS_HI: begin
                out_next.spi_byte = {6'b0, head_cmd.top[9:8]};
                out_next.is_data  = 1'b1;
            end
            ST_YS_LO: begin
                out_next.spi_byte = head_cmd.top[7:0];
                out_next.is_data  = 1'b1;
            end
            ST_YE_HI: begin
                out_next.spi_byte = {4'b0, head_cmd.bottom[11:8]};
                out_next.is_data  = 1'b1;
            end
            ST_YE_LO: begin
                out_next.spi_byte = head_cmd.bottom[7:0];
                out_next.is_data  = 1'b1;
            end
            ST_RAMWR: begin
                out_next.spi_byte = CMD_RAMWR;
                is_last           = !head_cmd.tall;
            end
            ST_RAMWRC: begin
                out_next.spi_byte = CMD_RAMWRC;
                is_last           = 1'b1;
            end
            default: begin
                out_next.spi_byte = CMD_RAMWR;
            end
        endcase
        out_next.last_of_run = is_last;
        pop                  = fire && is_last;
    end

    // Output register valid tracking.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ST_START;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_run_ends_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_last) |=> (step_reg == ST_START))
        else $error("sequencer did not return to start after last byte");
    a_busy_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != ST_START) |-> head_valid)
        else $error("sequencer mid-run without a descriptor at queue head");
    a_last_is_write_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_of_run) |->
            ((m_data.spi_byte == CMD_RAMWR || m_data.spi_byte == CMD_RAMWRC)
             && !m_data.is_data))
        else $error("run ended on a byte other than a memory write command");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lcdwcs_pkg::*;

    localparam int PANEL_WIDTH = 320;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    rect_req_t s_data;
    logic      m_valid;
    logic      m_ready;
    spi_byte_t m_data;

    // Shadow of the stored column and page windows.
    logic [11:0] stored_left;
    logic [11:0] stored_right;
    logic [11:0] stored_top;
    logic [11:0] stored_bottom;

    spi_byte_t expected_bytes[$];
    spi_byte_t want_byte;
    int        fail_count;
    int        quiet_cycles;
    int        sender_idle_pct;
    int        receiver_stall_pct;

    lcd_window_command_sequencer_core #(
        .PANEL_WIDTH(PANEL_WIDTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // Queue one expected panel byte.
    function automatic void push_byte(input logic [7:0] value, input logic data_flag,
                                      input logic final_flag);
        spi_byte_t b;
        b.spi_byte    = value;
        b.is_data     = data_flag;
        b.last_of_run = final_flag;
        expected_bytes.push_back(b);
    endfunction

    // Address set command with its start edge and, if it moved, its end edge.
    function automatic void push_address_set(input logic [7:0] opcode,
                                             input logic [11:0] start_edge,
                                             input logic [11:0] end_edge,
                                             input logic with_end);
        push_byte(opcode, 1'b0, 1'b0);
        push_byte({4'h0, start_edge[11:8]}, 1'b1, 1'b0);
        push_byte(start_edge[7:0], 1'b1, 1'b0);
        if (with_end) begin
            push_byte({4'h0, end_edge[11:8]}, 1'b1, 1'b0);
            push_byte(end_edge[7:0], 1'b1, 1'b0);
        end
    endfunction

    // Work out the byte run for one rectangle and update the stored windows.
    function automatic void predict_run(input rect_req_t r);
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] width;
        logic [11:0] height;
        logic [11:0] right;
        logic [11:0] bottom;
        left   = {2'b00, r.left_col};
        top    = {2'b00, r.top_row};
        width  = (r.win_width == '0) ? 12'd1 : {1'b0, r.win_width};
        height = (r.win_height == '0) ? 12'd1 : {1'b0, r.win_height};

        right = left + width - 12'd1;
        if (height == 12'd1) begin
            if (stored_right != EDGE_NONE && stored_right > right) begin
                right = stored_right;
            end else begin
                right = 12'(PANEL_WIDTH - 1);
            end
        end
        if (left != stored_left || right != stored_right) begin
            push_address_set(CMD_CASET, left, right, right != stored_right);
            stored_left  = left;
            stored_right = right;
        end

        bottom = top + height - 12'd1;
        if (top != stored_top || bottom != stored_bottom) begin
            push_address_set(CMD_PASET, top, bottom, bottom != stored_bottom);
            stored_top    = top;
            stored_bottom = bottom;
        end

        // The memory write opener closes a single-row run; tall windows add a continue that closes it.
        push_byte(CMD_RAMWR, 1'b0, height == 12'd1);
        if (height > 12'd1) begin
            push_byte(CMD_RAMWRC, 1'b0, 1'b1);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_rect(input logic [9:0] left, input logic [9:0] top,
                             input logic [10:0] width, input logic [10:0] height);
        rect_req_t r;
        r.left_col   = left;
        r.top_row    = top;
        r.win_width  = width;
        r.win_height = height;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_run(r);
        @(negedge aclk);
    endtask

    // Extent with a bias toward small sizes, sometimes the full field range.
    function automatic logic [10:0] random_extent();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) begin
            return 11'd1;
        end else if (pick < 60) begin
            return 11'($urandom_range(64, 2));
        end else if (pick < 90) begin
            return 11'($urandom_range(1024, 1));
        end
        return 11'($urandom_range(2047, 0));
    endfunction

    task automatic test_edge_extremes();
        // First single-row window with no stored right edge, then repeats.
        send_rect(10'd0, 10'd0, 11'd1, 11'd1);
        send_rect(10'd0, 10'd0, 11'd1, 11'd1);
        // Zero sizes behave as one.
        send_rect(10'd7, 10'd9, 11'd0, 11'd0);
        send_rect(10'd0, 10'd0, 11'd0, 11'd0);
        // Widest edges reach into the high nibble.
        send_rect(10'd1023, 10'd1023, 11'd2047, 11'd2047);
        send_rect(10'd1023, 10'd1023, 11'd1024, 11'd1024);
        send_rect(10'd512, 10'd512, 11'd512, 11'd512);
        send_rect(10'd341, 10'd682, 11'd1365, 11'd682);
        send_rect(10'd682, 10'd341, 11'd682, 11'd1365);
        send_rect(10'd256, 10'd256, 11'd256, 11'd256);
        send_rect(10'd0, 10'd0, 11'd1024, 11'd1024);
    endtask

    task automatic test_partial_windows();
        send_rect(10'd0, 10'd0, 11'd100, 11'd10);
        // Start edge moves while the end edge stays put.
        send_rect(10'd50, 10'd0, 11'd50, 11'd10);
        send_rect(10'd50, 10'd5, 11'd50, 11'd5);
        // Unchanged window sends only the write commands.
        send_rect(10'd50, 10'd5, 11'd50, 11'd5);
        send_rect(10'd256, 10'd256, 11'd256, 11'd256);
    endtask

    task automatic test_single_row();
        send_rect(10'd0, 10'd0, 11'd100, 11'd10);
        // Stored right edge is wider and is kept.
        send_rect(10'd0, 10'd20, 11'd10, 11'd1);
        // Stored right edge is narrower, so the panel edge is used.
        send_rect(10'd0, 10'd20, 11'd200, 11'd1);
        send_rect(10'd0, 10'd20, 11'd400, 11'd1);
        send_rect(10'd900, 10'd1023, 11'd2047, 11'd1);
        send_rect(10'd5, 10'd21, 11'd1, 11'd1);
    endtask

    task automatic test_random_rects(input int count, input int idle_pct,
                                     input int stall_pct);
        int pick;
        int lo;
        int hi;
        logic [9:0]  left;
        logic [9:0]  top;
        logic [10:0] width;
        logic [10:0] height;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        left   = 10'($urandom_range(1023));
        top    = 10'($urandom_range(1023));
        width  = random_extent();
        height = random_extent();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                // Same rectangle again.
            end else if (pick < 40 && stored_right != EDGE_NONE) begin
                // Move the start column but keep the stored right edge.
                lo = (int'(stored_right) > 2046) ? int'(stored_right) - 2046 : 0;
                hi = (int'(stored_right) > 1023) ? 1023 : int'(stored_right);
                left  = 10'($urandom_range(hi, lo));
                width = 11'(int'(stored_right) - int'(left) + 1);
                if (height <= 11'd1) begin
                    height = 11'($urandom_range(64, 2));
                end
            end else if (pick < 55 && stored_bottom != EDGE_NONE) begin
                // Move the start row but keep the stored bottom edge.
                lo = (int'(stored_bottom) > 2046) ? int'(stored_bottom) - 2046 : 0;
                hi = (int'(stored_bottom) > 1023) ? 1023 : int'(stored_bottom);
                top    = 10'($urandom_range(hi, lo));
                height = 11'(int'(stored_bottom) - int'(top) + 1);
            end else if (pick < 65) begin
                // Single-row strip on a new line.
                top    = 10'($urandom_range(1023));
                width  = random_extent();
                height = 11'd1;
            end else begin
                left   = 10'($urandom_range(1023));
                top    = 10'($urandom_range(1023));
                width  = random_extent();
                height = random_extent();
            end
            send_rect(left, top, width, height);
        end
    endtask

    // Receiver back-pressure is decided at each falling edge.
    always @(negedge aclk) begin
        m_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each byte taken from the block with the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte: spi_byte actual %h", m_data.spi_byte);
                fail_count++;
            end else begin
                want_byte = expected_bytes.pop_front();
                if (m_data.spi_byte !== want_byte.spi_byte) begin
                    $error("spi_byte mismatch: expected %h actual %h",
                           want_byte.spi_byte, m_data.spi_byte);
                    fail_count++;
                end
                if (m_data.is_data !== want_byte.is_data) begin
                    $error("is_data mismatch: expected %b actual %b",
                           want_byte.is_data, m_data.is_data);
                    fail_count++;
                end
                if (m_data.last_of_run !== want_byte.last_of_run) begin
                    $error("last_of_run mismatch: expected %b actual %b",
                           want_byte.last_of_run, m_data.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles in which neither channel moves a request or a byte.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        aclk               = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        m_ready            = 1'b0;
        fail_count         = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stored_left        = EDGE_NONE;
        stored_right       = EDGE_NONE;
        stored_top         = EDGE_NONE;
        stored_bottom      = EDGE_NONE;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_edge_extremes();
        test_partial_windows();
        test_single_row();
        test_random_rects(90, 0, 0);
        test_random_rects(90, 64, 0);
        test_random_rects(90, 0, 64);
        test_random_rects(90, 18, 18);
        s_valid <= 1'b0;

        // Drain the outstanding bytes, then watch for stray ones.
        while (expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
